### src/polyline_to_smooth_bezier_top_assert.svh
// Assertion macros used by the top RTL file of the smoothing block.
`ifndef POLYLINE_TO_SMOOTH_BEZIER_TOP_ASSERT_SVH
`define POLYLINE_TO_SMOOTH_BEZIER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition a implies condition c in the same cycle.
`define PBZ_ASSERT_SAME(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("same-cycle check failed");
// Condition a implies condition c in the next cycle.
`define PBZ_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");
`else
`define PBZ_ASSERT_SAME(lbl, clk, rst, a, c)
`define PBZ_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

### src/pbz_pkg.sv
`default_nettype none
package pbz_pkg;

   // Gain register.
   localparam int SMOOTH_WIDTH = 9;
   localparam logic [SMOOTH_WIDTH-1:0] SMOOTH_RESET = 9'd205;

   // Segment kinds.
   localparam logic KIND_MOVE  = 1'b0;
   localparam logic KIND_CURVE = 1'b1;

   // Ratio format, Q0.16 with room for one.
   localparam int FRAC_WIDTH = 17;
   localparam logic [FRAC_WIDTH-1:0] FRAC_ONE = 17'h10000;
   localparam int SF_WIDTH = SMOOTH_WIDTH + FRAC_WIDTH;
   localparam int ROUND_SHIFT = 25;

   // Back end sequencer states.
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DIFF,
      BK_SQX,
      BK_SQY,
      BK_ROOT,
      BK_DIVLD,
      BK_DIV,
      BK_MULA,
      BK_MULB,
      BK_MULC,
      BK_EMIT
   } back_state_type;

endpackage
`default_nettype wire

### src/polyline_to_smooth_bezier_top.sv
// A move beat goes from the front pending slot through the job queue to BK_EMIT;
// a curve beat also steps through the back end root, divide and multiply states.
// The back end takes no new job until it emits the last; it has one root, divide
// and multiply sequencer. Jobs queue ahead of it in the job queue.
// Reset is synchronous, active high: window, point count, queues and sequencer
// clear, and the gain returns to 205. No clearing pass is needed.
`default_nettype none
`include "polyline_to_smooth_bezier_top_assert.svh"
module polyline_to_smooth_bezier_top #(
   parameter int COORD_WIDTH  = 24,
   parameter int JOB_DEPTH    = 2,
   parameter int RESULT_DEPTH = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic signed [COORD_WIDTH-1:0]    req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0]    req_point_y,
   input  wire logic                             req_last_point,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_segment_kind,
   output logic signed [COORD_WIDTH-1:0]         rsp_ctrl1_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_ctrl1_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_ctrl2_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_ctrl2_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_end_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_end_y,
   output logic                                  rsp_final_result,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pbz_pkg::SMOOTH_WIDTH-1:0] csr_smoothing
);
   localparam int W  = COORD_WIDTH;
   localparam int JW = 8 * W + 3;
   localparam int RW = 6 * W + 2;

   typedef struct packed {
      logic                kind;
      logic signed [W-1:0] c1x;
      logic signed [W-1:0] c1y;
      logic signed [W-1:0] c2x;
      logic signed [W-1:0] c2y;
      logic signed [W-1:0] ex;
      logic signed [W-1:0] ey;
      logic                fin;
   } res_type;

   logic [pbz_pkg::SMOOTH_WIDTH-1:0] smoothing_ff;
   logic          job_valid, job_full, job_empty, job_pop;
   logic [JW-1:0] front_job, back_job;
   logic          res_push, res_full;
   logic [RW-1:0] back_res, rsp_raw;
   res_type       rsp_beat;

   // Gain register, written one beat at a time.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         smoothing_ff <= pbz_pkg::SMOOTH_RESET;
      end else if (csr_valid && csr_ready) begin
         smoothing_ff <= csr_smoothing;
      end
   end

   pbz_front #(.W(W)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_last_point (req_last_point),
      .job_valid      (job_valid),
      .job_data       (front_job),
      .job_full       (job_full)
   );

   pbz_queue #(.DW(JW), .DEPTH(JOB_DEPTH)) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_valid),
      .din   (front_job),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (back_job),
      .empty (job_empty)
   );

   pbz_back #(.W(W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .smoothing (smoothing_ff),
      .job_empty (job_empty),
      .job_data  (back_job),
      .job_pop   (job_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (back_res)
   );

   pbz_queue #(.DW(RW), .DEPTH(RESULT_DEPTH)) u_res_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (back_res),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (rsp_raw),
      .empty (rsp_empty)
   );

   // Unpack the oldest result beat onto the ports.
   assign rsp_beat         = res_type'(rsp_raw);
   assign rsp_segment_kind = rsp_beat.kind;
   assign rsp_ctrl1_x      = rsp_beat.c1x;
   assign rsp_ctrl1_y      = rsp_beat.c1y;
   assign rsp_ctrl2_x      = rsp_beat.c2x;
   assign rsp_ctrl2_y      = rsp_beat.c2y;
   assign rsp_end_x        = rsp_beat.ex;
   assign rsp_end_y        = rsp_beat.ey;
   assign rsp_final_result = rsp_beat.fin;

   // The back end only pushes a result when the output queue has room.
   `PBZ_ASSERT_SAME(a_res_room, clock, reset, res_push, !res_full)
   // The back end never pops an empty job queue.
   `PBZ_ASSERT_SAME(a_job_pop, clock, reset, job_pop, !job_empty)
   // The gain only changes on a write beat.
   `PBZ_ASSERT_NEXT(a_gain_hold, clock, reset, !(csr_valid && csr_ready), $stable(smoothing_ff))
endmodule
`default_nettype wire

### src/pbz_queue.sv
`default_nettype none
module pbz_queue #(
   parameter int DW    = 8,
   parameter int DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [DW-1:0] din,
   output logic               full,
   input  wire logic          pop,
   output logic [DW-1:0]      dout,
   output logic               empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DW-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // Pointer and fill count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end
endmodule
`default_nettype wire

### src/pbz_front.sv
`default_nettype none
module pbz_front #(
   parameter int W = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic signed [W-1:0] req_point_x,
   input  wire logic signed [W-1:0] req_point_y,
   input  wire logic                req_last_point,
   output logic                     job_valid,
   output logic [8*W+2:0]           job_data,
   input  wire logic                job_full
);
   typedef struct packed {
      logic                move;
      logic                closing;
      logic                fin;
      logic signed [W-1:0] x0;
      logic signed [W-1:0] y0;
      logic signed [W-1:0] x1;
      logic signed [W-1:0] y1;
      logic signed [W-1:0] x2;
      logic signed [W-1:0] y2;
      logic signed [W-1:0] x3;
      logic signed [W-1:0] y3;
   } job_type;

   logic signed [W-1:0] wx0_ff, wx1_ff, wx2_ff, wy0_ff, wy1_ff, wy2_ff;
   logic [1:0]          seen_ff, seen_in;
   logic [1:0]          pend_valid_ff, pend_valid_in;
   job_type             pend0_ff, pend1_ff, new0, new1;
   logic                new0_v, new1_v, accept, send;

   assign req_full  = |pend_valid_ff;
   assign accept    = req_push && !req_full;
   assign job_valid = pend_valid_ff[0];
   assign job_data  = pend0_ff;
   assign send      = pend_valid_ff[0] && !job_full;

   // Classify the point and build the jobs it causes, oldest first.
   always_comb begin
      job_type mv, sa, sc;
      mv         = '0;
      mv.move    = 1'b1;
      mv.fin     = req_last_point;
      mv.x2      = req_point_x;
      mv.y2      = req_point_y;
      sa         = '0;
      sa.x0      = (seen_ff == 2'd2) ? wx1_ff : wx2_ff;
      sa.y0      = (seen_ff == 2'd2) ? wy1_ff : wy2_ff;
      sa.x1      = wx1_ff;
      sa.y1      = wy1_ff;
      sa.x2      = wx0_ff;
      sa.y2      = wy0_ff;
      sa.x3      = req_point_x;
      sa.y3      = req_point_y;
      sc         = '0;
      sc.closing = 1'b1;
      sc.fin     = 1'b1;
      sc.x0      = (seen_ff == 2'd1) ? wx0_ff : wx1_ff;
      sc.y0      = (seen_ff == 2'd1) ? wy0_ff : wy1_ff;
      sc.x1      = wx0_ff;
      sc.y1      = wy0_ff;
      sc.x2      = req_point_x;
      sc.y2      = req_point_y;
      sc.x3      = req_point_x;
      sc.y3      = req_point_y;
      new1       = sc;
      new1_v     = 1'b0;
      if (seen_ff == 2'd0) begin
         new0   = mv;
         new0_v = 1'b1;
      end else if (seen_ff == 2'd1) begin
         new0   = sc;
         new0_v = req_last_point;
      end else begin
         new0   = sa;
         new0_v = 1'b1;
         new1_v = req_last_point;
      end
      if (req_last_point) begin
         seen_in = 2'd0;
      end else if (seen_ff != 2'd3) begin
         seen_in = seen_ff + 2'd1;
      end else begin
         seen_in = seen_ff;
      end
   end

   // Pending slots drain into the job queue one beat a cycle while it is not full.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = {new1_v, new0_v};
      end else if (send) begin
         pend_valid_in = {1'b0, pend_valid_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= '0;
         seen_ff       <= '0;
         wx0_ff        <= '0;
         wx1_ff        <= '0;
         wx2_ff        <= '0;
         wy0_ff        <= '0;
         wy1_ff        <= '0;
         wy2_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         if (accept) begin
            seen_ff <= seen_in;
            wx2_ff  <= wx1_ff;
            wx1_ff  <= wx0_ff;
            wx0_ff  <= req_point_x;
            wy2_ff  <= wy1_ff;
            wy1_ff  <= wy0_ff;
            wy0_ff  <= req_point_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend0_ff <= new0;
         pend1_ff <= new1;
      end else if (send) begin
         pend0_ff <= pend1_ff;
      end
   end
endmodule
`default_nettype wire

### src/pbz_back.sv
`default_nettype none
module pbz_back #(
   parameter int W = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [pbz_pkg::SMOOTH_WIDTH-1:0] smoothing,
   input  wire logic                             job_empty,
   input  wire logic [8*W+2:0]                   job_data,
   output logic                                  job_pop,
   input  wire logic                             res_full,
   output logic                                  res_push,
   output logic [6*W+1:0]                        res_data
);
   localparam int LW  = W + 1;
   localparam int SQW = 2 * LW;
   localparam int NW  = LW + 16;
   localparam int CW  = $clog2(NW + 1);
   localparam int PW  = pbz_pkg::SF_WIDTH + W + 1;
   localparam int RW  = PW + 1 - pbz_pkg::ROUND_SHIFT;

   typedef struct packed {
      logic                move;
      logic                closing;
      logic                fin;
      logic signed [W-1:0] x0;
      logic signed [W-1:0] y0;
      logic signed [W-1:0] x1;
      logic signed [W-1:0] y1;
      logic signed [W-1:0] x2;
      logic signed [W-1:0] y2;
      logic signed [W-1:0] x3;
      logic signed [W-1:0] y3;
   } job_type;

   typedef struct packed {
      logic                kind;
      logic signed [W-1:0] c1x;
      logic signed [W-1:0] c1y;
      logic signed [W-1:0] c2x;
      logic signed [W-1:0] c2y;
      logic signed [W-1:0] ex;
      logic signed [W-1:0] ey;
      logic                fin;
   } res_type;

   pbz_pkg::back_state_type state_ff, state_in;
   job_type               job_ff, job_in;
   logic [1:0]            idx_ff, idx_in;
   logic [W-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [SQW-1:0]        sq_ff, sq_in, rt_ff, rt_in, bit_ff, bit_in;
   logic [LW-1:0]         la_ff, la_in, lb_ff, lb_in, lc_ff, lc_in;
   logic [LW:0]           den_ff, den_in, rem_ff, rem_in;
   logic [NW-1:0]         qn_ff, qn_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [pbz_pkg::FRAC_WIDTH-1:0] k1_ff, k1_in, k2_ff, k2_in;
   logic [pbz_pkg::SF_WIDTH-1:0]   sf_ff, sf_in;
   logic [W:0]            ad_ff, ad_in;
   logic                  neg_ff, neg_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic signed [W-1:0]   c1x_ff, c1y_ff, c2x_ff, c2y_ff;
   logic signed [W-1:0]   c1x_in, c1y_in, c2x_in, c2y_in;

   // Difference of two coordinates, one bit wider.
   function automatic logic signed [W:0] sub(input logic signed [W-1:0] b,
                                            input logic signed [W-1:0] a);
      return {b[W-1], b} - {a[W-1], a};
   endfunction

   // Magnitude of a widened difference.
   function automatic logic [W:0] mag(input logic signed [W:0] d);
      return d[W] ? -d : d;
   endfunction

   // Curves: 3 roots, 2 divisions, 4 rounded offsets (2 when closing).
   always_comb begin
      logic signed [W-1:0]   ax, ay, bx, by, base;
      logic signed [W:0]     d;
      logic [W:0]            mx, my;
      logic [SQW-1:0]        trial;
      logic [LW+1:0]         t;
      logic [LW-1:0]         na, nb;
      logic [pbz_pkg::FRAC_WIDTH-1:0] frac;
      logic [PW:0]           rsum;
      logic [RW-1:0]         r;
      logic signed [RW:0]    v;
      logic signed [W-1:0]   s;
      res_type               res;
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sq_in    = sq_ff;
      rt_in    = rt_ff;
      bit_in   = bit_ff;
      la_in    = la_ff;
      lb_in    = lb_ff;
      lc_in    = lc_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      qn_in    = qn_ff;
      cnt_in   = cnt_ff;
      k1_in    = k1_ff;
      k2_in    = k2_ff;
      sf_in    = sf_ff;
      ad_in    = ad_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      c1x_in   = c1x_ff;
      c1y_in   = c1y_ff;
      c2x_in   = c2x_ff;
      c2y_in   = c2y_ff;
      job_pop  = 1'b0;
      res_push = 1'b0;
      ax = job_ff.x0;
      ay = job_ff.y0;
      bx = job_ff.x1;
      by = job_ff.y1;
      d  = '0;
      mx = '0;
      my = '0;
      base = job_ff.x1;
      trial = rt_ff + bit_ff;
      t  = {rem_ff, qn_ff[NW-1]};
      na = la_ff;
      nb = lb_ff;
      frac = k2_ff;
      rsum = {1'b0, prod_ff} + (PW+1)'(1 << (pbz_pkg::ROUND_SHIFT - 1));
      r  = rsum[PW:pbz_pkg::ROUND_SHIFT];
      v  = '0;
      s  = '0;

      case (state_ff)
         pbz_pkg::BK_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               job_in  = job_type'(job_data);
               idx_in  = 2'd0;
               state_in = job_in.move ? pbz_pkg::BK_EMIT : pbz_pkg::BK_DIFF;
            end
         end
         pbz_pkg::BK_DIFF: begin
            case (idx_ff)
               2'd0: begin
                  ax = job_ff.x0; ay = job_ff.y0; bx = job_ff.x1; by = job_ff.y1;
               end
               2'd1: begin
                  ax = job_ff.x1; ay = job_ff.y1; bx = job_ff.x2; by = job_ff.y2;
               end
               default: begin
                  ax = job_ff.x2; ay = job_ff.y2; bx = job_ff.x3; by = job_ff.y3;
               end
            endcase
            mx       = mag(sub(bx, ax));
            my       = mag(sub(by, ay));
            dx_in    = mx[W-1:0];
            dy_in    = my[W-1:0];
            state_in = pbz_pkg::BK_SQX;
         end
         pbz_pkg::BK_SQX: begin
            sq_in    = SQW'(dx_ff * dx_ff);
            state_in = pbz_pkg::BK_SQY;
         end
         pbz_pkg::BK_SQY: begin
            sq_in    = sq_ff + SQW'(dy_ff * dy_ff);
            rt_in    = '0;
            bit_in   = SQW'(1) << (SQW - 2);
            state_in = pbz_pkg::BK_ROOT;
         end
         pbz_pkg::BK_ROOT: begin
            // One result bit per cycle.
            if (bit_ff == '0) begin
               case (idx_ff)
                  2'd0:    la_in = rt_ff[LW-1:0];
                  2'd1:    lb_in = rt_ff[LW-1:0];
                  default: lc_in = rt_ff[LW-1:0];
               endcase
               if (idx_ff == 2'd2) begin
                  idx_in   = 2'd0;
                  state_in = pbz_pkg::BK_DIVLD;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = pbz_pkg::BK_DIFF;
               end
            end else begin
               if (sq_ff >= trial) begin
                  sq_in = sq_ff - trial;
                  rt_in = (rt_ff >> 1) + bit_ff;
               end else begin
                  rt_in = rt_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         pbz_pkg::BK_DIVLD: begin
            na       = idx_ff[0] ? lb_ff : la_ff;
            nb       = idx_ff[0] ? lc_ff : lb_ff;
            den_in   = {1'b0, na} + {1'b0, nb};
            qn_in    = {na, 16'd0};
            rem_in   = '0;
            cnt_in   = CW'(NW);
            state_in = pbz_pkg::BK_DIV;
         end
         pbz_pkg::BK_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (cnt_ff == '0) begin
               if (idx_ff[0]) begin
                  k2_in    = (den_ff == '0) ? '0 : qn_ff[pbz_pkg::FRAC_WIDTH-1:0];
                  idx_in   = 2'd0;
                  state_in = pbz_pkg::BK_MULA;
               end else begin
                  k1_in    = (den_ff == '0) ? '0 : qn_ff[pbz_pkg::FRAC_WIDTH-1:0];
                  idx_in   = 2'd1;
                  state_in = pbz_pkg::BK_DIVLD;
               end
            end else begin
               if (t >= {1'b0, den_ff}) begin
                  rem_in = (LW+1)'(t - {1'b0, den_ff});
                  qn_in  = {qn_ff[NW-2:0], 1'b1};
               end else begin
                  rem_in = t[LW:0];
                  qn_in  = {qn_ff[NW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 1'b1;
            end
         end
         pbz_pkg::BK_MULA: begin
            case (idx_ff)
               2'd0:    d = sub(job_ff.x2, job_ff.x0);
               2'd1:    d = sub(job_ff.y2, job_ff.y0);
               2'd2:    d = sub(job_ff.x3, job_ff.x1);
               default: d = sub(job_ff.y3, job_ff.y1);
            endcase
            frac     = idx_ff[1] ? k2_ff : pbz_pkg::FRAC_ONE - k1_ff;
            sf_in    = smoothing * frac;
            ad_in    = mag(d);
            neg_in   = d[W] ^ idx_ff[1];
            state_in = pbz_pkg::BK_MULB;
         end
         pbz_pkg::BK_MULB: begin
            prod_in  = sf_ff * ad_ff;
            state_in = pbz_pkg::BK_MULC;
         end
         pbz_pkg::BK_MULC: begin
            // Round half away from zero, add to the anchor point, saturate.
            case (idx_ff)
               2'd0:    base = job_ff.x1;
               2'd1:    base = job_ff.y1;
               2'd2:    base = job_ff.x2;
               default: base = job_ff.y2;
            endcase
            v = neg_ff ? (RW+1)'(base) - $signed({1'b0, r})
                       : (RW+1)'(base) + $signed({1'b0, r});
            if (v[RW:W-1] == '0 || v[RW:W-1] == '1) begin
               s = v[W-1:0];
            end else begin
               s = v[RW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            case (idx_ff)
               2'd0:    c1x_in = s;
               2'd1:    c1y_in = s;
               2'd2:    c2x_in = s;
               default: c2y_in = s;
            endcase
            if (idx_ff == 2'd3 || (idx_ff == 2'd1 && job_ff.closing)) begin
               state_in = pbz_pkg::BK_EMIT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = pbz_pkg::BK_MULA;
            end
         end
         pbz_pkg::BK_EMIT: begin
            res_push = !res_full;
            if (!res_full) begin
               state_in = pbz_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = pbz_pkg::BK_IDLE;
         end
      endcase

      // Result beat assembled from the held job and control points.
      res.kind = job_ff.move ? pbz_pkg::KIND_MOVE : pbz_pkg::KIND_CURVE;
      res.c1x  = job_ff.move ? '0 : c1x_ff;
      res.c1y  = job_ff.move ? '0 : c1y_ff;
      res.c2x  = job_ff.move ? '0 : (job_ff.closing ? job_ff.x2 : c2x_ff);
      res.c2y  = job_ff.move ? '0 : (job_ff.closing ? job_ff.y2 : c2y_ff);
      res.ex   = job_ff.x2;
      res.ey   = job_ff.y2;
      res.fin  = job_ff.fin;
      res_data = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbz_pkg::BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sq_ff   <= sq_in;
      rt_ff   <= rt_in;
      bit_ff  <= bit_in;
      la_ff   <= la_in;
      lb_ff   <= lb_in;
      lc_ff   <= lc_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      qn_ff   <= qn_in;
      cnt_ff  <= cnt_in;
      k1_ff   <= k1_in;
      k2_ff   <= k2_in;
      sf_ff   <= sf_in;
      ad_ff   <= ad_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      c1x_ff  <= c1x_in;
      c1y_ff  <= c1y_in;
      c2x_ff  <= c2x_in;
      c2y_ff  <= c2y_in;
   end
endmodule
`default_nettype wire
